FILE: rtl/vrp_pkg.sv
// Package for the vertex rotate and project block: payload types, register
// codes, datapath widths and the sine table.
// Depends on nothing; every other file of the block imports it.
package vrp_pkg;

    // Angle resolution and the quarter turn that turns sine into cosine.
    localparam int ANGLE_STEPS = 256;
    localparam int ANGLE_W     = $clog2(ANGLE_STEPS);
    localparam logic [ANGLE_W-1:0] QUARTER_TURN = ANGLE_W'(ANGLE_STEPS / 4);

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_DIST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y  = 3'd4;

    // Divider widths: magnitude of rot * focal is at most 2^14, depth is 1..254.
    localparam int DIV_NUM_W = 15;
    localparam int DIV_DEN_W = 8;

    typedef struct packed {
        logic signed [7:0] vert_x;
        logic signed [7:0] vert_y;
        logic signed [7:0] vert_z;
        logic [7:0]        angle_x;
        logic [7:0]        angle_y;
        logic [7:0]        angle_z;
    } t_vertex;

    typedef struct packed {
        logic signed [7:0] rot_x;
        logic signed [7:0] rot_y;
        logic signed [7:0] rot_z;
        logic signed [7:0] screen_x;
        logic signed [7:0] screen_y;
    } t_result;

    // Sine table, amplitude 110, one full turn.
    localparam logic signed [7:0] SINE_LUT [ANGLE_STEPS] = '{
        8'sd0, 8'sd2, 8'sd5, 8'sd8, 8'sd10, 8'sd13, 8'sd16, 8'sd18,
        8'sd21, 8'sd24, 8'sd26, 8'sd29, 8'sd31, 8'sd34, 8'sd37, 8'sd39,
        8'sd42, 8'sd44, 8'sd47, 8'sd49, 8'sd51, 8'sd54, 8'sd56, 8'sd58,
        8'sd61, 8'sd63, 8'sd65, 8'sd67, 8'sd69, 8'sd71, 8'sd73, 8'sd75,
        8'sd77, 8'sd79, 8'sd81, 8'sd83, 8'sd85, 8'sd86, 8'sd88, 8'sd89,
        8'sd91, 8'sd92, 8'sd94, 8'sd95, 8'sd97, 8'sd98, 8'sd99, 8'sd100,
        8'sd101, 8'sd102, 8'sd103, 8'sd104, 8'sd105, 8'sd106, 8'sd106, 8'sd107,
        8'sd107, 8'sd108, 8'sd108, 8'sd109, 8'sd109, 8'sd109, 8'sd109, 8'sd109,
        8'sd110, 8'sd109, 8'sd109, 8'sd109, 8'sd109, 8'sd109, 8'sd108, 8'sd108,
        8'sd107, 8'sd107, 8'sd106, 8'sd106, 8'sd105, 8'sd104, 8'sd103, 8'sd102,
        8'sd101, 8'sd100, 8'sd99, 8'sd98, 8'sd97, 8'sd95, 8'sd94, 8'sd92,
        8'sd91, 8'sd89, 8'sd88, 8'sd86, 8'sd85, 8'sd83, 8'sd81, 8'sd79,
        8'sd77, 8'sd75, 8'sd73, 8'sd71, 8'sd69, 8'sd67, 8'sd65, 8'sd63,
        8'sd61, 8'sd58, 8'sd56, 8'sd54, 8'sd51, 8'sd49, 8'sd47, 8'sd44,
        8'sd42, 8'sd39, 8'sd37, 8'sd34, 8'sd31, 8'sd29, 8'sd26, 8'sd24,
        8'sd21, 8'sd18, 8'sd16, 8'sd13, 8'sd10, 8'sd8, 8'sd5, 8'sd2,
        8'sd0, -8'sd2, -8'sd5, -8'sd8, -8'sd10, -8'sd13, -8'sd16, -8'sd18,
        -8'sd21, -8'sd24, -8'sd26, -8'sd29, -8'sd31, -8'sd34, -8'sd37, -8'sd39,
        -8'sd42, -8'sd44, -8'sd47, -8'sd49, -8'sd51, -8'sd54, -8'sd56, -8'sd58,
        -8'sd61, -8'sd63, -8'sd65, -8'sd67, -8'sd69, -8'sd71, -8'sd73, -8'sd75,
        -8'sd77, -8'sd79, -8'sd81, -8'sd83, -8'sd85, -8'sd86, -8'sd88, -8'sd89,
        -8'sd91, -8'sd92, -8'sd94, -8'sd95, -8'sd97, -8'sd98, -8'sd99, -8'sd100,
        -8'sd101, -8'sd102, -8'sd103, -8'sd104, -8'sd105, -8'sd106, -8'sd106, -8'sd107,
        -8'sd107, -8'sd108, -8'sd108, -8'sd109, -8'sd109, -8'sd109, -8'sd109, -8'sd109,
        -8'sd110, -8'sd109, -8'sd109, -8'sd109, -8'sd109, -8'sd109, -8'sd108, -8'sd108,
        -8'sd107, -8'sd107, -8'sd106, -8'sd106, -8'sd105, -8'sd104, -8'sd103, -8'sd102,
        -8'sd101, -8'sd100, -8'sd99, -8'sd98, -8'sd97, -8'sd95, -8'sd94, -8'sd92,
        -8'sd91, -8'sd89, -8'sd88, -8'sd86, -8'sd85, -8'sd83, -8'sd81, -8'sd79,
        -8'sd77, -8'sd75, -8'sd73, -8'sd71, -8'sd69, -8'sd67, -8'sd65, -8'sd63,
        -8'sd61, -8'sd58, -8'sd56, -8'sd54, -8'sd51, -8'sd49, -8'sd47, -8'sd44,
        -8'sd42, -8'sd39, -8'sd37, -8'sd34, -8'sd31, -8'sd29, -8'sd26, -8'sd24,
        -8'sd21, -8'sd18, -8'sd16, -8'sd13, -8'sd10, -8'sd8, -8'sd5, -8'sd2
    };

endpackage

FILE: rtl/vrp_in_if.sv
// Input channel of the vertex rotate and project block: one vertex per item.
// Depends on vrp_pkg for the payload type.
interface vrp_in_if;
    import vrp_pkg::*;

    logic    valid;
    logic    ready;
    t_vertex data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/vrp_out_if.sv
// Output channel of the vertex rotate and project block: one result per item.
// Depends on vrp_pkg for the payload type.
interface vrp_out_if;
    import vrp_pkg::*;

    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/vertex_rotate_project.sv
// Vertex rotate and project: top level with the rotation pipeline, the
// projection stages and two vrp_div dividers. Depends on vrp_pkg, vrp_in_if,
// vrp_out_if and vrp_div.
//
// Usage: each item on i_vert is one vertex with three angles. The block rotates
// it about X, Y and Z and projects it; one item on o_res carries the rotated
// coordinates and the screen position. Items are accepted when valid and
// ready are both high, one per cycle when the receiver keeps up.
// The accepting edge loads the first of eight stages of table lookup, products
// and sums; fifteen divider stages (one quotient bit per stage) and the output
// register follow. Throughput is one item per cycle while the receiver keeps up.
// When the receiver holds ready low with a result waiting, the whole pipeline
// freezes and i_vert.ready drops in the same cycle; nothing is lost or repeated.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data; the
// user must write it only while the block is idle, which the block itself
// does not enforce. Writes to unused indices are ignored. Synchronous reset
// empties the pipeline and loads the register defaults (view distance 80,
// focal factor 60, near limit 10, centres 64).
module vertex_rotate_project (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [vrp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [vrp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    vrp_in_if.sink                        i_vert,
    vrp_out_if.source                     o_res
);
    import vrp_pkg::*;

    localparam int PRE_N = 8;

    typedef struct packed {
        logic signed [7:0] rx;
        logic signed [7:0] ry;
        logic signed [7:0] rz;
        logic              neg_x;
        logic              neg_y;
    } t_side;

    // Configuration registers.
    logic signed [7:0] r_view_dist;
    logic signed [7:0] r_focal;
    logic [6:0]        r_near;
    logic [6:0]        r_center_x;
    logic [6:0]        r_center_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_dist <= 8'sd80;
            r_focal     <= 8'sd60;
            r_near      <= 7'd10;
            r_center_x  <= 7'd64;
            r_center_y  <= 7'd64;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_VIEW_DIST: r_view_dist <= i_cfg_data;
                CFG_FOCAL:     r_focal     <= i_cfg_data;
                CFG_NEAR:      r_near      <= i_cfg_data[6:0];
                CFG_CENTER_X:  r_center_x  <= i_cfg_data[6:0];
                CFG_CENTER_Y:  r_center_y  <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // The pipeline moves as one whenever the output register can take an item.
    logic w_en;
    logic r_out_v;
    assign w_en = !r_out_v || o_res.ready;
    assign i_vert.ready = w_en;

    logic [PRE_N-1:0]     r_v;
    logic [DIV_NUM_W-1:0] r_dv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_dv    <= '0;
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_v     <= {r_v[PRE_N-2:0], i_vert.valid};
            r_dv    <= {r_dv[DIV_NUM_W-2:0], r_v[PRE_N-1]};
            r_out_v <= r_dv[DIV_NUM_W-1];
        end
    end

    // Stage 1: register the vertex and look up sine and cosine.
    logic signed [7:0] r1_x, r1_y, r1_z;
    logic signed [7:0] r1_sx, r1_cx, r1_sy, r1_cy, r1_sz, r1_cz;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_x  <= i_vert.data.vert_x;
            r1_y  <= i_vert.data.vert_y;
            r1_z  <= i_vert.data.vert_z;
            r1_sx <= SINE_LUT[i_vert.data.angle_x];
            r1_cx <= SINE_LUT[ANGLE_W'(i_vert.data.angle_x + QUARTER_TURN)];
            r1_sy <= SINE_LUT[i_vert.data.angle_y];
            r1_cy <= SINE_LUT[ANGLE_W'(i_vert.data.angle_y + QUARTER_TURN)];
            r1_sz <= SINE_LUT[i_vert.data.angle_z];
            r1_cz <= SINE_LUT[ANGLE_W'(i_vert.data.angle_z + QUARTER_TURN)];
        end
    end

    // Stage 2: products of the X rotation.
    logic signed [15:0] r2_ycx, r2_zsx, r2_ysx, r2_zcx;
    logic signed [7:0]  r2_x, r2_sy, r2_cy, r2_sz, r2_cz;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_ycx <= 16'(r1_y) * 16'(r1_cx);
            r2_zsx <= 16'(r1_z) * 16'(r1_sx);
            r2_ysx <= 16'(r1_y) * 16'(r1_sx);
            r2_zcx <= 16'(r1_z) * 16'(r1_cx);
            r2_x   <= r1_x;
            r2_sy  <= r1_sy;
            r2_cy  <= r1_cy;
            r2_sz  <= r1_sz;
            r2_cz  <= r1_cz;
        end
    end

    // Stage 3: sums of the X rotation, floor shift by 7.
    logic signed [16:0] w3_y, w3_z;
    logic signed [9:0]  r3_y, r3_z;
    logic signed [7:0]  r3_x, r3_sy, r3_cy, r3_sz, r3_cz;

    assign w3_y = 17'(r2_ycx) - 17'(r2_zsx);
    assign w3_z = 17'(r2_ysx) + 17'(r2_zcx);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_y  <= 10'(w3_y >>> 7);
            r3_z  <= 10'(w3_z >>> 7);
            r3_x  <= r2_x;
            r3_sy <= r2_sy;
            r3_cy <= r2_cy;
            r3_sz <= r2_sz;
            r3_cz <= r2_cz;
        end
    end

    // Stage 4: products of the Y rotation.
    logic signed [17:0] r4_xcy, r4_zsy, r4_xsy, r4_zcy;
    logic signed [9:0]  r4_y;
    logic signed [7:0]  r4_sz, r4_cz;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_xcy <= 18'(r3_x) * 18'(r3_cy);
            r4_zsy <= 18'(r3_z) * 18'(r3_sy);
            r4_xsy <= 18'(r3_x) * 18'(r3_sy);
            r4_zcy <= 18'(r3_z) * 18'(r3_cy);
            r4_y   <= r3_y;
            r4_sz  <= r3_sz;
            r4_cz  <= r3_cz;
        end
    end

    // Stage 5: sums of the Y rotation.
    logic signed [18:0] w5_x, w5_z;
    logic signed [9:0]  r5_x, r5_z, r5_y;
    logic signed [7:0]  r5_sz, r5_cz;

    assign w5_x = 19'(r4_xcy) + 19'(r4_zsy);
    assign w5_z = 19'(r4_zcy) - 19'(r4_xsy);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_x  <= 10'(w5_x >>> 7);
            r5_z  <= 10'(w5_z >>> 7);
            r5_y  <= r4_y;
            r5_sz <= r4_sz;
            r5_cz <= r4_cz;
        end
    end

    // Stage 6: products of the Z rotation; z is final after the Y rotation.
    logic signed [17:0] r6_xcz, r6_ysz, r6_xsz, r6_ycz;
    logic signed [7:0]  r6_rz;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_xcz <= 18'(r5_x) * 18'(r5_cz);
            r6_ysz <= 18'(r5_y) * 18'(r5_sz);
            r6_xsz <= 18'(r5_x) * 18'(r5_sz);
            r6_ycz <= 18'(r5_y) * 18'(r5_cz);
            r6_rz  <= 8'(r5_z);
        end
    end

    // Stage 7: sums of the Z rotation and the clamped depth.
    logic signed [18:0] w7_x, w7_y;
    logic signed [8:0]  w7_d;
    logic [6:0]         w7_lim;
    logic signed [7:0]  r7_rx, r7_ry, r7_rz;
    logic [7:0]         r7_depth;

    assign w7_x   = 19'(r6_xcz) - 19'(r6_ysz);
    assign w7_y   = 19'(r6_xsz) + 19'(r6_ycz);
    assign w7_d   = 9'(r6_rz) + 9'(r_view_dist);
    assign w7_lim = (r_near == 7'd0) ? 7'd1 : r_near;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_rx    <= 8'(w7_x >>> 7);
            r7_ry    <= 8'(w7_y >>> 7);
            r7_rz    <= r6_rz;
            r7_depth <= (w7_d < $signed({2'b00, w7_lim})) ? {1'b0, w7_lim} : w7_d[7:0];
        end
    end

    // Stage 8: numerators and their magnitudes for the dividers.
    logic signed [15:0]   w8_px, w8_py;
    logic [DIV_NUM_W-1:0] r8_mx, r8_my;
    logic [7:0]           r8_depth;
    t_side                r8_side;

    assign w8_px = 16'(r7_rx) * 16'(r_focal);
    assign w8_py = 16'(r7_ry) * 16'(r_focal);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_mx         <= DIV_NUM_W'(w8_px[15] ? -w8_px : w8_px);
            r8_my         <= DIV_NUM_W'(w8_py[15] ? -w8_py : w8_py);
            r8_depth      <= r7_depth;
            r8_side.rx    <= r7_rx;
            r8_side.ry    <= r7_ry;
            r8_side.rz    <= r7_rz;
            r8_side.neg_x <= w8_px[15];
            r8_side.neg_y <= w8_py[15];
        end
    end

    // Dividers, with the side data running alongside.
    logic [DIV_NUM_W-1:0] w_qx, w_qy;
    t_side                r_sd [DIV_NUM_W];

    vrp_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r8_mx),
        .i_den (r8_depth),
        .o_quo (w_qx)
    );

    vrp_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r8_my),
        .i_den (r8_depth),
        .o_quo (w_qy)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd[0] <= r8_side;
            for (int k = 1; k < DIV_NUM_W; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    // Output register: restore the quotient signs and add the centres, wrapping.
    t_side      w_s;
    logic [7:0] w_qx8, w_qy8;
    t_result    r_out;

    assign w_s   = r_sd[DIV_NUM_W-1];
    assign w_qx8 = w_s.neg_x ? 8'(-w_qx) : w_qx[7:0];
    assign w_qy8 = w_s.neg_y ? 8'(-w_qy) : w_qy[7:0];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.rot_x    <= w_s.rx;
            r_out.rot_y    <= w_s.ry;
            r_out.rot_z    <= w_s.rz;
            r_out.screen_x <= {1'b0, r_center_x} + w_qx8;
            r_out.screen_y <= {1'b0, r_center_y} - w_qy8;
        end
    end

    assign o_res.valid = r_out_v;
    assign o_res.data  = r_out;

    // A stall freezes every valid bit of the pipeline.
    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_v) && $stable(r_dv)))
        else $error("pipeline valid bits moved during a stall");

    // The divisor handed to the dividers is never zero.
    a_depth_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[PRE_N-2] |-> (r7_depth != 8'd0))
        else $error("clamped depth is zero");

    // A result leaves only for an item that entered the divider chain earlier.
    a_out_from_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_out_v)) |-> $past(r_dv[DIV_NUM_W-1]))
        else $error("result appeared without an item behind it");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_v)
        else $error("output valid after reset");
endmodule

FILE: rtl/vrp_div.sv
// Pipelined unsigned restoring divider, one quotient bit per register stage.
// Depends on vrp_pkg for the default widths.
module vrp_div #(
    parameter int NUM_W = vrp_pkg::DIV_NUM_W,
    parameter int DEN_W = vrp_pkg::DIV_DEN_W
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo
);
    import vrp_pkg::*;

    logic [NUM_W-1:0] r_num [NUM_W];
    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [DEN_W-1:0] r_den [NUM_W];
    logic [NUM_W-1:0] n_num [NUM_W];
    logic [DEN_W-1:0] n_rem [NUM_W];
    logic [NUM_W-1:0] w_pn  [NUM_W];
    logic [DEN_W-1:0] w_pr  [NUM_W];
    logic [DEN_W-1:0] w_pd  [NUM_W];
    logic [DEN_W:0]   w_rs  [NUM_W];
    logic             w_ge  [NUM_W];

    // Each stage shifts one dividend bit into the remainder and subtracts if it can.
    always_comb begin
        for (int k = 0; k < NUM_W; k++) begin
            if (k == 0) begin
                w_pn[k] = i_num;
                w_pr[k] = '0;
                w_pd[k] = i_den;
            end else begin
                w_pn[k] = r_num[k-1];
                w_pr[k] = r_rem[k-1];
                w_pd[k] = r_den[k-1];
            end
            w_rs[k] = {w_pr[k], w_pn[k][NUM_W-1]};
            w_ge[k] = (w_rs[k] >= {1'b0, w_pd[k]});
            n_rem[k] = w_ge[k] ? DEN_W'(w_rs[k] - {1'b0, w_pd[k]}) : DEN_W'(w_rs[k]);
            n_num[k] = {w_pn[k][NUM_W-2:0], w_ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NUM_W; k++) begin
                r_num[k] <= n_num[k];
                r_rem[k] <= n_rem[k];
                r_den[k] <= w_pd[k];
            end
        end
    end

    // After the last stage the shifted dividend has become the quotient.
    assign o_quo = r_num[NUM_W-1];
endmodule

FILE: dv/tb_vertex_rotate_project.sv
// Self-checking testbench for vertex_rotate_project: random and directed vertices
// through the valid/ready channels, checked in order against an in-bench predictor.
// Depends on vrp_pkg, vrp_in_if, vrp_out_if and the block itself.
module tb_vertex_rotate_project;
    import vrp_pkg::*;

    // Register copy plus the queue of projected results still to arrive.
    class projection_scoreboard;
        logic signed [7:0] view_dist;
        logic signed [7:0] focal;
        logic [6:0]        near_lim;
        logic [6:0]        cen_x;
        logic [6:0]        cen_y;
        t_result           pending[$];
        int                n_err;

        function void reset_regs();
            view_dist = 8'sd80;
            focal     = 8'sd60;
            near_lim  = 7'd10;
            cen_x     = 7'd64;
            cen_y     = 7'd64;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
            case (idx)
                CFG_VIEW_DIST: view_dist = val;
                CFG_FOCAL:     focal = val;
                CFG_NEAR:      near_lim = val[6:0];
                CFG_CENTER_X:  cen_x = val[6:0];
                CFG_CENTER_Y:  cen_y = val[6:0];
                default: ;
            endcase
        endfunction

        // Floor shift by 7 of a full precision sum.
        function int shr7(int v);
            return v >>> 7;
        endfunction

        function void note_vertex(t_vertex v);
            int x, y, z, t1, t2, sx, cx, sy, cy, sz, cz, depth, lim, qx, qy;
            logic signed [7:0] rx, ry, rz;
            t_result r;
            x = v.vert_x; y = v.vert_y; z = v.vert_z;
            sx = SINE_LUT[v.angle_x]; cx = SINE_LUT[8'(v.angle_x + QUARTER_TURN)];
            sy = SINE_LUT[v.angle_y]; cy = SINE_LUT[8'(v.angle_y + QUARTER_TURN)];
            sz = SINE_LUT[v.angle_z]; cz = SINE_LUT[8'(v.angle_z + QUARTER_TURN)];
            t1 = shr7(y * cx - z * sx); t2 = shr7(y * sx + z * cx);
            y = t1; z = t2;
            t1 = shr7(x * cy + z * sy); t2 = shr7(-x * sy + z * cy);
            x = t1; z = t2;
            t1 = shr7(x * cz - y * sz); t2 = shr7(x * sz + y * cz);
            rx = t1[7:0]; ry = t2[7:0]; rz = z[7:0];
            depth = int'(rz) + int'(view_dist);
            lim = (near_lim == 0) ? 1 : int'(near_lim);
            if (depth < lim) depth = lim;
            // SystemVerilog integer division truncates toward zero.
            qx = (int'(rx) * int'(focal)) / depth;
            qy = (int'(ry) * int'(focal)) / depth;
            t1 = int'(cen_x) + qx;
            t2 = int'(cen_y) - qy;
            r.rot_x = rx; r.rot_y = ry; r.rot_z = rz;
            r.screen_x = t1[7:0]; r.screen_y = t2[7:0];
            pending.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("Unexpected result item %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                n_err++;
                if (n_err <= 10)
                    $display({"Mismatch: expected rx %0d ry %0d rz %0d sx %0d sy %0d,",
                              " got rx %0d ry %0d rz %0d sx %0d sy %0d"},
                             want.rot_x, want.rot_y, want.rot_z,
                             want.screen_x, want.screen_y,
                             got.rot_x, got.rot_y, got.rot_z,
                             got.screen_x, got.screen_y);
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    vrp_in_if  vert_ch ();
    vrp_out_if res_ch ();

    projection_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  hold_off_cycles;

    vertex_rotate_project u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_vert     (vert_ch.sink),
        .o_res      (res_ch.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit well above the slowest correct run.
    initial begin
        #20000000;
        $display("FAILURE");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off when asked for.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) sb.check_result(res_ch.data);
            if (hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offers one vertex, idling first at random, and waits for its acceptance.
    // Valid stays high afterwards so that the next item can follow at once.
    task automatic send_vertex(t_vertex v);
        while ($urandom_range(99) < send_idle_pct) begin
            vert_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        vert_ch.valid <= 1'b1;
        vert_ch.data  <= v;
        @(posedge i_clk);
        while (!vert_ch.ready) @(posedge i_clk);
        sb.note_vertex(v);
    endtask

    // Stops offering and waits until every expected result has come.
    task automatic drain();
        vert_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge i_clk);
    endtask

    function automatic t_vertex rand_vertex();
        t_vertex v;
        v.vert_x  = 8'($urandom);
        v.vert_y  = 8'($urandom);
        v.vert_z  = 8'($urandom);
        v.angle_x = 8'($urandom);
        v.angle_y = 8'($urandom);
        v.angle_z = 8'($urandom);
        return v;
    endfunction

    task automatic rand_config();
        write_reg(CFG_VIEW_DIST, 8'($urandom));
        write_reg(CFG_FOCAL, 8'($urandom));
        write_reg(CFG_NEAR, 8'($urandom_range(127)));
        write_reg(CFG_CENTER_X, 8'($urandom_range(127)));
        write_reg(CFG_CENTER_Y, 8'($urandom_range(127)));
    endtask

    initial begin
        t_vertex v;
        logic signed [7:0] edge_vals [4];
        sb = new();
        sb.reset_regs();
        sb.n_err = 0;
        edge_vals = '{-8'sd128, 8'sd127, 8'sd0, -8'sd1};
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        vert_ch.valid = 1'b0; vert_ch.data = '0;
        send_idle_pct = 19; recv_idle_pct = 77;
        hold_off_cycles = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, with quadrant angles about X, at reset settings.
        for (int i = 0; i < 16; i++) begin
            v.vert_x = edge_vals[i % 4];
            v.vert_y = edge_vals[(i / 4) % 4];
            v.vert_z = edge_vals[(i + 1) % 4];
            v.angle_x = 8'(i * 64); v.angle_y = 8'(i * 32 + 255); v.angle_z = 8'(i * 16 + 128);
            send_vertex(v);
        end
        // Large negative depth clamps to the near limit, including a limit of zero.
        drain();
        write_reg(CFG_VIEW_DIST, 8'h80);
        write_reg(CFG_NEAR, 8'd0);
        write_reg(CFG_FOCAL, 8'h80);
        write_reg(CFG_CENTER_X, 8'd127);
        write_reg(CFG_CENTER_Y, 8'd0);
        write_reg(3'd7, 8'hFF);
        for (int i = 0; i < 4; i++) begin
            v = '{edge_vals[i], edge_vals[3 - i], 8'sd127, 8'd0, 8'd0, 8'(i * 64)};
            send_vertex(v);
        end
        drain();
        write_reg(CFG_VIEW_DIST, 8'h7F);
        write_reg(CFG_FOCAL, 8'h7F);
        write_reg(CFG_NEAR, 8'd127);
        write_reg(CFG_CENTER_X, 8'd0);
        write_reg(CFG_CENTER_Y, 8'd127);
        for (int i = 0; i < 4; i++) send_vertex(rand_vertex());

        // Long receiver hold-off while the sender keeps offering.
        send_idle_pct = 0;
        hold_off_cycles = 200;
        for (int i = 0; i < 60; i++) send_vertex(rand_vertex());
        drain();

        // Random phases: sender-light idling, then reversed, then none.
        for (int ph = 0; ph < 6; ph++) begin
            send_idle_pct = (ph < 2) ? 19 : (ph < 4) ? 77 : 0;
            recv_idle_pct = (ph < 2) ? 77 : (ph < 4) ? 19 : 0;
            rand_config();
            for (int i = 0; i < 330; i++) begin
                send_vertex(rand_vertex());
            end
            drain();
        end

        if (sb.n_err == 0 && sb.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
